FILE: rtl/core/bcm_pkg.sv
package bcm_pkg;

    localparam int MASS_W  = 48;
    localparam int RAD_W   = 32;
    localparam int POS_W   = 40;
    localparam int VEL_W   = 48;
    localparam int COEFF_W = 64;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 64'd33433930;

    // Channels of the mass-weighted means.
    localparam int NCH   = 4;
    localparam int CH_PX = 0;
    localparam int CH_PY = 1;
    localparam int CH_VX = 2;
    localparam int CH_VY = 3;

    localparam int MAG_W  = 48;
    localparam int PROD_W = 96;
    localparam int SUM_W  = 97;
    localparam int TOT_W  = 49;
    localparam int DEN_W  = 50;
    localparam int NUM_W  = 98;
    localparam int QUO_W  = 48;

    // The divider sets the depth of the main pipeline.
    localparam int DIV_STAGES = QUO_W;

    localparam int PRAW_W     = 112;
    localparam int CBRT_IN_W  = 96;
    localparam int ROOT_W     = 32;
    localparam int CBRT_STEPS = 32;
    localparam int CREM_W     = 68;
    localparam int CSH_W      = 71;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [RAD_W-1:0]  radius;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_y;
    } body_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              tot_zero;
        logic              rad_sat;
        logic [MASS_W-1:0] mass_sat;
        logic [NCH-1:0]    neg;
        body_t             body_a;
    } side_t;

endpackage

FILE: rtl/core/bcm_front.sv
module bcm_front
    import bcm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [MASS_W-1:0]            mass_a,
    input  logic [RAD_W-1:0]             radius_a,
    input  logic signed [POS_W-1:0]      pos_ax,
    input  logic signed [POS_W-1:0]      pos_ay,
    input  logic signed [VEL_W-1:0]      vel_ax,
    input  logic signed [VEL_W-1:0]      vel_ay,
    input  logic [MASS_W-1:0]            mass_b,
    input  logic [RAD_W-1:0]             radius_b,
    input  logic signed [POS_W-1:0]      pos_bx,
    input  logic signed [POS_W-1:0]      pos_by,
    input  logic signed [VEL_W-1:0]      vel_bx,
    input  logic signed [VEL_W-1:0]      vel_by,
    input  logic [COEFF_W-1:0]           coeff,
    output side_t                        side_o,
    output logic [NCH-1:0][NUM_W-1:0]    num_o,
    output logic [DEN_W-1:0]             den_o,
    output logic [CBRT_IN_W-1:0]         root_in_o
);

    // Entry logic: differences, magnitudes and sums.
    logic [POS_W:0]               dx_full;
    logic [POS_W:0]               dy_full;
    logic [NCH-1:0][MAG_W-1:0]    a_val;
    logic [NCH-1:0][MAG_W-1:0]    b_val;
    body_t                        body_in;

    always_comb
    begin
        dx_full = {pos_bx[POS_W-1], pos_bx} - {pos_ax[POS_W-1], pos_ax};
        dy_full = {pos_by[POS_W-1], pos_by} - {pos_ay[POS_W-1], pos_ay};
        a_val[CH_PX] = {{(MAG_W-POS_W){pos_ax[POS_W-1]}}, pos_ax};
        a_val[CH_PY] = {{(MAG_W-POS_W){pos_ay[POS_W-1]}}, pos_ay};
        a_val[CH_VX] = vel_ax;
        a_val[CH_VY] = vel_ay;
        b_val[CH_PX] = {{(MAG_W-POS_W){pos_bx[POS_W-1]}}, pos_bx};
        b_val[CH_PY] = {{(MAG_W-POS_W){pos_by[POS_W-1]}}, pos_by};
        b_val[CH_VX] = vel_bx;
        b_val[CH_VY] = vel_by;
        body_in.mass   = mass_a;
        body_in.radius = radius_a;
        body_in.pos_x  = pos_ax;
        body_in.pos_y  = pos_ay;
        body_in.vel_x  = vel_ax;
        body_in.vel_y  = vel_ay;
    end

    // Stage 1
    logic                      s1_valid_reg;
    logic [POS_W:0]            s1_dxm_reg, s1_dym_reg;
    logic [RAD_W:0]            s1_s_reg;
    logic [TOT_W-1:0]          s1_total_reg;
    logic [MASS_W-1:0]         s1_ma_reg, s1_mb_reg;
    logic [NCH-1:0][MAG_W-1:0] s1_amag_reg, s1_bmag_reg;
    logic [NCH-1:0]            s1_aneg_reg, s1_bneg_reg;
    body_t                     s1_body_reg;

    // Stage 2
    logic                      s2_valid_reg;
    logic [61:0]               s2_dxl_reg, s2_dyl_reg;
    logic [60:0]               s2_dxh_reg, s2_dyh_reg;
    logic [65:0]               s2_ss_reg;
    logic [NCH-1:0][71:0]      s2_pal_reg, s2_pah_reg, s2_pbl_reg, s2_pbh_reg;
    logic [NCH-1:0]            s2_aneg_reg, s2_bneg_reg;
    logic [TOT_W-1:0]          s2_total_reg;
    logic [MASS_W-1:0]         s2_msat_reg;
    body_t                     s2_body_reg;

    // Stage 3
    logic                      s3_valid_reg;
    logic [81:0]               s3_d2_reg;
    logic [65:0]               s3_ss_reg;
    logic [NCH-1:0][PROD_W-1:0] s3_pa_reg, s3_pb_reg;
    logic [NCH-1:0]            s3_aneg_reg, s3_bneg_reg;
    logic [TOT_W-1:0]          s3_total_reg;
    logic [MASS_W-1:0]         s3_msat_reg;
    logic [55:0]               s3_cll_reg, s3_clh_reg, s3_chl_reg, s3_chh_reg;
    body_t                     s3_body_reg;

    // Stage 4
    logic                      s4_valid_reg;
    logic                      s4_hit_reg;
    logic [NCH-1:0][SUM_W-1:0] s4_m_reg;
    logic [NCH-1:0]            s4_neg_reg;
    logic [TOT_W-1:0]          s4_total_reg;
    logic [MASS_W-1:0]         s4_msat_reg;
    logic [PRAW_W-1:0]         s4_p_reg;
    body_t                     s4_body_reg;

    // Stage 5
    logic                      s5_valid_reg;
    side_t                     s5_side_reg;
    logic [NCH-1:0][NUM_W-1:0] s5_num_reg;
    logic [DEN_W-1:0]          s5_den_reg;
    logic [CBRT_IN_W-1:0]      s5_root_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1
            s1_dxm_reg   <= dx_full[POS_W] ? (POS_W+1)'(0) - dx_full : dx_full;
            s1_dym_reg   <= dy_full[POS_W] ? (POS_W+1)'(0) - dy_full : dy_full;
            s1_s_reg     <= (RAD_W+1)'(radius_a) + (RAD_W+1)'(radius_b);
            s1_total_reg <= TOT_W'(mass_a) + TOT_W'(mass_b);
            s1_ma_reg    <= mass_a;
            s1_mb_reg    <= mass_b;
            s1_body_reg  <= body_in;
            for (int i = 0; i < NCH; i++)
            begin
                s1_aneg_reg[i] <= a_val[i][MAG_W-1];
                s1_bneg_reg[i] <= b_val[i][MAG_W-1];
                s1_amag_reg[i] <= a_val[i][MAG_W-1] ? MAG_W'(0) - a_val[i] : a_val[i];
                s1_bmag_reg[i] <= b_val[i][MAG_W-1] ? MAG_W'(0) - b_val[i] : b_val[i];
            end

            // Stage 2: partial products.
            s2_dxl_reg   <= 62'(s1_dxm_reg) * 62'(s1_dxm_reg[20:0]);
            s2_dxh_reg   <= 61'(s1_dxm_reg) * 61'(s1_dxm_reg[40:21]);
            s2_dyl_reg   <= 62'(s1_dym_reg) * 62'(s1_dym_reg[20:0]);
            s2_dyh_reg   <= 61'(s1_dym_reg) * 61'(s1_dym_reg[40:21]);
            s2_ss_reg    <= 66'(s1_s_reg) * 66'(s1_s_reg);
            s2_total_reg <= s1_total_reg;
            s2_msat_reg  <= s1_total_reg[TOT_W-1] ? {MASS_W{1'b1}}
                                                  : s1_total_reg[MASS_W-1:0];
            s2_aneg_reg  <= s1_aneg_reg;
            s2_bneg_reg  <= s1_bneg_reg;
            s2_body_reg  <= s1_body_reg;
            for (int i = 0; i < NCH; i++)
            begin
                s2_pal_reg[i] <= 72'(s1_ma_reg) * 72'(s1_amag_reg[i][23:0]);
                s2_pah_reg[i] <= 72'(s1_ma_reg) * 72'(s1_amag_reg[i][47:24]);
                s2_pbl_reg[i] <= 72'(s1_mb_reg) * 72'(s1_bmag_reg[i][23:0]);
                s2_pbh_reg[i] <= 72'(s1_mb_reg) * 72'(s1_bmag_reg[i][47:24]);
            end

            // Stage 3: sum the partials, start the radius product.
            s3_d2_reg    <= 82'(s2_dxl_reg) + (82'(s2_dxh_reg) << 21)
                          + 82'(s2_dyl_reg) + (82'(s2_dyh_reg) << 21);
            s3_ss_reg    <= s2_ss_reg;
            s3_total_reg <= s2_total_reg;
            s3_msat_reg  <= s2_msat_reg;
            s3_aneg_reg  <= s2_aneg_reg;
            s3_bneg_reg  <= s2_bneg_reg;
            s3_body_reg  <= s2_body_reg;
            s3_cll_reg   <= 56'(coeff[31:0])  * 56'(s2_msat_reg[23:0]);
            s3_clh_reg   <= 56'(coeff[31:0])  * 56'(s2_msat_reg[47:24]);
            s3_chl_reg   <= 56'(coeff[63:32]) * 56'(s2_msat_reg[23:0]);
            s3_chh_reg   <= 56'(coeff[63:32]) * 56'(s2_msat_reg[47:24]);
            for (int i = 0; i < NCH; i++)
            begin
                s3_pa_reg[i] <= PROD_W'(s2_pal_reg[i]) + (PROD_W'(s2_pah_reg[i]) << 24);
                s3_pb_reg[i] <= PROD_W'(s2_pbl_reg[i]) + (PROD_W'(s2_pbh_reg[i]) << 24);
            end

            // Stage 4: collision test and signed combine.
            s4_hit_reg   <= (s3_d2_reg != 82'd0) && ({s3_d2_reg, 16'd0} < 98'(s3_ss_reg));
            s4_total_reg <= s3_total_reg;
            s4_msat_reg  <= s3_msat_reg;
            s4_body_reg  <= s3_body_reg;
            s4_p_reg     <= PRAW_W'(s3_cll_reg) + (PRAW_W'(s3_clh_reg) << 24)
                          + (PRAW_W'(s3_chl_reg) << 32) + (PRAW_W'(s3_chh_reg) << 56);
            for (int i = 0; i < NCH; i++)
            begin
                if (s3_aneg_reg[i] == s3_bneg_reg[i])
                begin
                    s4_m_reg[i]   <= SUM_W'(s3_pa_reg[i]) + SUM_W'(s3_pb_reg[i]);
                    s4_neg_reg[i] <= s3_aneg_reg[i];
                end
                else if (s3_pa_reg[i] < s3_pb_reg[i])
                begin
                    s4_m_reg[i]   <= SUM_W'(s3_pb_reg[i] - s3_pa_reg[i]);
                    s4_neg_reg[i] <= s3_bneg_reg[i];
                end
                else
                begin
                    s4_m_reg[i]   <= SUM_W'(s3_pa_reg[i] - s3_pb_reg[i]);
                    s4_neg_reg[i] <= s3_aneg_reg[i];
                end
            end

            // Stage 5: rounding offset and divider operands.
            s5_side_reg.valid    <= s4_valid_reg;
            s5_side_reg.hit      <= s4_hit_reg;
            s5_side_reg.tot_zero <= (s4_total_reg == TOT_W'(0));
            s5_side_reg.rad_sat  <= (s4_p_reg[PRAW_W-1:88] != 24'd0);
            s5_side_reg.mass_sat <= s4_msat_reg;
            s5_side_reg.neg      <= s4_neg_reg;
            s5_side_reg.body_a   <= s4_body_reg;
            s5_den_reg           <= {s4_total_reg, 1'b0};
            s5_root_in_reg       <= {s4_p_reg[87:0], 8'd0};
            for (int i = 0; i < NCH; i++)
            begin
                s5_num_reg[i] <= {s4_m_reg[i], 1'b0} + NUM_W'(s4_total_reg);
            end
        end
    end

    // The valid bit handed on is the reset one.
    always_comb
    begin
        side_o       = s5_side_reg;
        side_o.valid = s5_valid_reg;
    end

    assign num_o     = s5_num_reg;
    assign den_o     = s5_den_reg;
    assign root_in_o = s5_root_in_reg;

endmodule

FILE: rtl/core/bcm_div.sv
module bcm_div
    import bcm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo
);

    // Restoring division, one quotient bit per stage. The low register
    // shifts numerator bits out at the top and quotient bits in at the bottom.
    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] lq_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] lq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   sh;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num[NUM_W-1:QUO_W];
            assign lq_in  = num[QUO_W-1:0];
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign lq_in  = lq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign sh = {rem_in, lq_in[QUO_W-1]};
        assign ge = (sh >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];
                lq_reg[k]  <= {lq_in[QUO_W-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = lq_reg[DIV_STAGES-1];

endmodule

FILE: rtl/core/bcm_cbrt.sv
module bcm_cbrt
    import bcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [CBRT_IN_W-1:0]  rad_in,
    output logic [ROOT_W-1:0]     root
);

    // Digit-by-digit cube root, three radicand bits per stage. Root and its
    // square are kept so each trial value 12*y^2 + 6*y + 1 needs only adds.
    // Stages past the last digit only carry the root to line up with the
    // divider.
    logic [ROOT_W-1:0]    y_reg   [DIV_STAGES];
    logic [2*ROOT_W-1:0]  ysq_reg [CBRT_STEPS];
    logic [CREM_W-1:0]    rem_reg [CBRT_STEPS];
    logic [CBRT_IN_W-1:0] v_reg   [CBRT_STEPS];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        if (k < CBRT_STEPS)
        begin : g_step
            logic [ROOT_W-1:0]    y_in;
            logic [2*ROOT_W-1:0]  ysq_in;
            logic [CREM_W-1:0]    rem_in;
            logic [CBRT_IN_W-1:0] v_in;
            logic [CSH_W-1:0]     rsh;
            logic [CSH_W-1:0]     trial;
            logic                 ge;

            if (k == 0)
            begin : g_first
                assign y_in   = '0;
                assign ysq_in = '0;
                assign rem_in = '0;
                assign v_in   = rad_in;
            end
            else
            begin : g_next
                assign y_in   = y_reg[k-1];
                assign ysq_in = ysq_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign v_in   = v_reg[k-1];
            end

            assign rsh   = {rem_in, v_in[CBRT_IN_W-1 -: 3]};
            assign trial = (CSH_W'(ysq_in) << 3) + (CSH_W'(ysq_in) << 2)
                         + (CSH_W'(y_in) << 2) + (CSH_W'(y_in) << 1) + CSH_W'(1);
            assign ge    = (rsh >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? CREM_W'(rsh - trial) : CREM_W'(rsh);
                    y_reg[k]   <= {y_in[ROOT_W-2:0], ge};
                    ysq_reg[k] <= ge ? (ysq_in << 2) + ((2*ROOT_W)'(y_in) << 2)
                                       + (2*ROOT_W)'(1)
                                     : (ysq_in << 2);
                    v_reg[k]   <= v_in << 3;
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    y_reg[k] <= y_reg[k-1];
                end
            end
        end
    end

    assign root = y_reg[DIV_STAGES-1];

endmodule

FILE: rtl/core/body_collision_merge.sv
// Merges two bodies that collide into one, perfectly inelastically.
// Input channel (in_valid/in_ready) carries one pair of bodies per transfer;
// output channel (out_valid/out_ready) returns one result body per pair,
// in order, with merged set when the pair collided. The configuration
// channel (cfg_valid/cfg_ready/cfg_data) writes radius_coeff; it is always
// ready and should only be written while no pair is in flight.
// Throughput is one pair per cycle while the receiver does not stall.
// From the input transfer to out_valid a pair passes five front stages
// (differences, split products, collision test, operand setup), then 48
// stages set by the bit-per-stage dividers for the weighted means, which
// the cube root runs beside, then the output register.
// Reset clears all valid bits and loads radius_coeff with its default.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is dropped or repeated,
// and in_ready returns as soon as out_ready does.
module body_collision_merge
    import bcm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [COEFF_W-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MASS_W-1:0]        mass_a,
    input  logic [RAD_W-1:0]         radius_a,
    input  logic signed [POS_W-1:0]  pos_ax,
    input  logic signed [POS_W-1:0]  pos_ay,
    input  logic signed [VEL_W-1:0]  vel_ax,
    input  logic signed [VEL_W-1:0]  vel_ay,
    input  logic [MASS_W-1:0]        mass_b,
    input  logic [RAD_W-1:0]         radius_b,
    input  logic signed [POS_W-1:0]  pos_bx,
    input  logic signed [POS_W-1:0]  pos_by,
    input  logic signed [VEL_W-1:0]  vel_bx,
    input  logic signed [VEL_W-1:0]  vel_by,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     merged,
    output logic [MASS_W-1:0]        out_mass,
    output logic [RAD_W-1:0]         out_radius,
    output logic signed [POS_W-1:0]  out_pos_x,
    output logic signed [POS_W-1:0]  out_pos_y,
    output logic signed [VEL_W-1:0]  out_vel_x,
    output logic signed [VEL_W-1:0]  out_vel_y
);

    logic [COEFF_W-1:0]        radius_coeff_reg;
    logic                      out_valid_reg;
    logic                      merged_reg;
    body_t                     out_body_reg;
    logic                      en;

    side_t                     front_side;
    logic [NCH-1:0][NUM_W-1:0] front_num;
    logic [DEN_W-1:0]          front_den;
    logic [CBRT_IN_W-1:0]      front_root_in;
    logic [NCH-1:0][QUO_W-1:0] quo;
    logic [ROOT_W-1:0]         root;
    side_t                     side_reg [DIV_STAGES];
    logic                      side_valid_reg [DIV_STAGES];
    side_t                     side_last;
    logic [NCH-1:0][QUO_W-1:0] mean;
    body_t                     out_body_next;

    // The pipeline advances whenever the output register is free or drains.
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_coeff_reg <= COEFF_RESET;
        end
        else if (cfg_valid)
        begin
            radius_coeff_reg <= cfg_data;
        end
    end

    bcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .mass_a    (mass_a),
        .radius_a  (radius_a),
        .pos_ax    (pos_ax),
        .pos_ay    (pos_ay),
        .vel_ax    (vel_ax),
        .vel_ay    (vel_ay),
        .mass_b    (mass_b),
        .radius_b  (radius_b),
        .pos_bx    (pos_bx),
        .pos_by    (pos_by),
        .vel_bx    (vel_bx),
        .vel_by    (vel_by),
        .coeff     (radius_coeff_reg),
        .side_o    (front_side),
        .num_o     (front_num),
        .den_o     (front_den),
        .root_in_o (front_root_in)
    );

    for (genvar i = 0; i < NCH; i++)
    begin : g_div
        bcm_div u_div (
            .clk (clk),
            .en  (en),
            .num (front_num[i]),
            .den (front_den),
            .quo (quo[i])
        );
    end

    bcm_cbrt u_cbrt (
        .clk    (clk),
        .en     (en),
        .rad_in (front_root_in),
        .root   (root)
    );

    // Per-item control and body A travel beside the dividers.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_side
        side_t side_in;
        logic  valid_in;

        if (k == 0)
        begin : g_first
            assign side_in  = front_side;
            assign valid_in = front_side.valid;
        end
        else
        begin : g_next
            assign side_in  = side_reg[k-1];
            assign valid_in = side_valid_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                side_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb
    begin
        side_last       = side_reg[DIV_STAGES-1];
        side_last.valid = side_valid_reg[DIV_STAGES-1];
    end

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            mean[i] = side_last.neg[i] ? QUO_W'(0) - quo[i] : quo[i];
        end

        out_body_next = side_last.body_a;
        if (side_last.hit)
        begin
            out_body_next.mass   = side_last.mass_sat;
            out_body_next.radius = side_last.rad_sat ? {RAD_W{1'b1}} : root;
            // With no mass at all the position and velocity of A stand.
            if (!side_last.tot_zero)
            begin
                out_body_next.pos_x = mean[CH_PX][POS_W-1:0];
                out_body_next.pos_y = mean[CH_PY][POS_W-1:0];
                out_body_next.vel_x = mean[CH_VX][VEL_W-1:0];
                out_body_next.vel_y = mean[CH_VY][VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            merged_reg   <= side_last.hit;
            out_body_reg <= out_body_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign merged     = merged_reg;
    assign out_mass   = out_body_reg.mass;
    assign out_radius = out_body_reg.radius;
    assign out_pos_x  = out_body_reg.pos_x;
    assign out_pos_y  = out_body_reg.pos_y;
    assign out_vel_x  = out_body_reg.vel_x;
    assign out_vel_y  = out_body_reg.vel_y;

    a_coeff_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> radius_coeff_reg == $past(cfg_data))
        else $error("radius coefficient not taken from the configuration transfer");

    a_zero_mass_radius: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merged && out_mass == '0 |-> out_radius == '0)
        else $error("merged body without mass has a nonzero radius");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(side_last) && $stable(quo) && $stable(root))
        else $error("pipeline tail moved during a stall");

    a_unmerged_keeps_a: assert property (@(posedge clk) disable iff (!rst_n)
        en && side_last.valid && !side_last.hit |=>
            !merged && out_mass == $past(side_last.body_a.mass))
        else $error("non-colliding pair did not return body A");

endmodule

FILE: tb/sv/tb_body_collision_merge.sv
module tb_body_collision_merge;
    import bcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 54;

    typedef struct packed {
        logic [MASS_W-1:0] ma;
        logic [RAD_W-1:0]  ra;
        logic [POS_W-1:0]  pax;
        logic [POS_W-1:0]  pay;
        logic [VEL_W-1:0]  vax;
        logic [VEL_W-1:0]  vay;
        logic [MASS_W-1:0] mb;
        logic [RAD_W-1:0]  rb;
        logic [POS_W-1:0]  pbx;
        logic [POS_W-1:0]  pby;
        logic [VEL_W-1:0]  vbx;
        logic [VEL_W-1:0]  vby;
    } pair_t;

    typedef struct packed {
        logic              merged;
        logic [MASS_W-1:0] mass;
        logic [RAD_W-1:0]  radius;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [VEL_W-1:0]  vx;
        logic [VEL_W-1:0]  vy;
    } merge_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [COEFF_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    pair_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic merged;
    logic [MASS_W-1:0] out_mass;
    logic [RAD_W-1:0] out_radius;
    logic signed [POS_W-1:0] out_pos_x, out_pos_y;
    logic signed [VEL_W-1:0] out_vel_x, out_vel_y;

    pair_t pending_pairs[$];
    merge_t expected_bodies[$];
    logic [COEFF_W-1:0] coeff_model;
    int errors = 0;
    int n_merged = 0;
    int n_passed = 0;
    int gap_left = 0;
    int hold_left = 0;
    int long_hold = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    bit drive_en = 1'b0;

    body_collision_merge u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mass_a(cur.ma), .radius_a(cur.ra), .pos_ax(cur.pax), .pos_ay(cur.pay),
        .vel_ax(cur.vax), .vel_ay(cur.vay),
        .mass_b(cur.mb), .radius_b(cur.rb), .pos_bx(cur.pbx), .pos_by(cur.pby),
        .vel_bx(cur.vbx), .vel_by(cur.vby),
        .out_valid(out_valid), .out_ready(out_ready), .merged(merged),
        .out_mass(out_mass), .out_radius(out_radius),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
        .out_vel_x(out_vel_x), .out_vel_y(out_vel_y)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Rounded mass-weighted mean, ties away from zero.
    function automatic logic signed [63:0] weighted_mean(input logic [47:0] ma,
            input logic signed [63:0] a, input logic [47:0] mb,
            input logic signed [63:0] b);
        logic signed [127:0] num;
        logic [127:0] mag_num, q;
        logic [127:0] tot;
        begin
            tot = 128'(ma) + 128'(mb);
            num = $signed({64'd0, ma}) * 128'(a) + $signed({64'd0, mb}) * 128'(b);
            mag_num = num < 0 ? -num : num;
            q = (2 * mag_num + tot) / (2 * tot);
            weighted_mean = num < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
        end
    endfunction

    function automatic logic [31:0] merged_radius(input logic [47:0] m);
        logic [127:0] v;
        logic [127:0] c;
        logic [31:0] r;
        begin
            v = (128'(coeff_model) * 128'(m)) << 8;
            r = '0;
            if (v[127:96] != 0)
                r = '1;
            else
                for (int i = 31; i >= 0; i--)
                begin
                    c = 128'(r | (32'd1 << i));
                    if (c * c * c <= v)
                        r = c[31:0];
                end
            merged_radius = r;
        end
    endfunction

    function automatic merge_t predict_merge(input pair_t p);
        merge_t e;
        logic signed [127:0] dx, dy;
        logic [127:0] d2, s;
        logic [48:0] tot;
        begin
            e = '{1'b0, p.ma, p.ra, p.pax, p.pay, p.vax, p.vay};
            dx = 128'($signed(p.pbx)) - 128'($signed(p.pax));
            dy = 128'($signed(p.pby)) - 128'($signed(p.pay));
            d2 = dx * dx + dy * dy;
            s = 128'(p.ra) + 128'(p.rb);
            if (d2 != 0 && (d2 << 16) < s * s)
            begin
                tot = 49'(p.ma) + 49'(p.mb);
                e.merged = 1'b1;
                e.mass = tot[48] ? '1 : tot[47:0];
                e.radius = merged_radius(e.mass);
                if (tot != 0)
                begin
                    e.px = POS_W'(weighted_mean(p.ma, $signed(p.pax), p.mb, $signed(p.pbx)));
                    e.py = POS_W'(weighted_mean(p.ma, $signed(p.pay), p.mb, $signed(p.pby)));
                    e.vx = VEL_W'(weighted_mean(p.ma, $signed(p.vax), p.mb, $signed(p.vbx)));
                    e.vy = VEL_W'(weighted_mean(p.ma, $signed(p.vay), p.mb, $signed(p.vby)));
                end
            end
            predict_merge = e;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic int pick_gap();
        pick_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                   ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    endfunction

    // Driver: prediction is made at the transfer so the coefficient in use matches.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_bodies.push_back(predict_merge(cur));
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (drive_en && pending_pairs.size() > 0)
            begin
                cur <= pending_pairs.pop_front();
                in_valid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver stall, counted on its own.
    always @(posedge clk)
    begin
        if (long_hold_req && !long_hold_done)
        begin
            long_hold <= 300;
            long_hold_done <= 1'b1;
        end
        else if (long_hold > 0)
            long_hold <= long_hold - 1;
    end

    // Monitor and receiver stalls.
    always @(posedge clk)
    begin
        merge_t e;
        if (out_valid && out_ready)
        begin
            if (expected_bodies.size() == 0)
            begin
                report_mismatch("unexpected result", out_mass, '0);
            end
            else
            begin
                e = expected_bodies.pop_front();
                if (e.merged) n_merged++; else n_passed++;
                if (merged !== e.merged) report_mismatch("merged", merged, e.merged);
                if (out_mass !== e.mass) report_mismatch("mass", out_mass, e.mass);
                if (out_radius !== e.radius) report_mismatch("radius", out_radius, e.radius);
                if (out_pos_x !== e.px) report_mismatch("pos_x", out_pos_x, e.px);
                if (out_pos_y !== e.py) report_mismatch("pos_y", out_pos_y, e.py);
                if (out_vel_x !== e.vx) report_mismatch("vel_x", out_vel_x, e.vx);
                if (out_vel_y !== e.vy) report_mismatch("vel_y", out_vel_y, e.vy);
            end
        end
        if (long_hold > 0)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            hold_left <= pick_gap();
        end
    end

    function automatic pair_t random_pair(input bit close);
        pair_t p;
        begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
            if (close)
            begin
                // Mostly nearby bodies with small radii so merges are frequent.
                p.pbx = p.pax + POS_W'($signed(24'($urandom)));
                p.pby = p.pay + POS_W'($signed(24'($urandom)));
                if ($urandom_range(0, 3) != 0)
                begin
                    p.ra = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom) >> 4;
                    p.rb = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom) >> 4;
                end
                if ($urandom_range(0, 3) == 0) p.ma = p.ma >> $urandom_range(0, 47);
                if ($urandom_range(0, 3) == 0) p.mb = p.mb >> $urandom_range(0, 47);
            end
            random_pair = p;
        end
    endfunction

    task automatic write_coeff(input logic [COEFF_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        coeff_model = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        drive_en = 1'b1;
        wait (pending_pairs.size() == 0 && !in_valid && expected_bodies.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
        drive_en = 1'b0;
    endtask

    function automatic pair_t pair_of(input logic [47:0] ma, input logic [31:0] ra,
            input logic [39:0] pax, input logic [47:0] vax, input logic [47:0] mb,
            input logic [31:0] rb, input logic [39:0] pbx, input logic [47:0] vbx);
        pair_of = '{ma, ra, pax, pax, vax, vax, mb, rb, pbx, pbx, vbx, vbx};
    endfunction

    initial
    begin
        logic [COEFF_W-1:0] coeffs[5];
        pair_t p;
        coeffs = '{COEFF_RESET, 64'd0, '1, 64'h0000_0100_0000_0000, 64'h8000_0000_0000_0000};
        coeff_model = COEFF_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed pairs at the reset coefficient.
        pending_pairs.push_back(pair_of('1, '1, 40'h80_0000_0000, 48'h8000_0000_0000,
                                        '1, '1, 40'h80_0000_0001, 48'h7FFF_FFFF_FFFF));
        pending_pairs.push_back(pair_of(48'd5, 32'h100_0000, 40'd1000, 48'd7,
                                        48'd3, 32'h100_0000, 40'd1000, 48'd9));
        pending_pairs.push_back(pair_of('0, 32'h100_0000, 40'd0, 48'd5,
                                        '0, 32'h100_0000, 40'd1, 48'd3));
        pending_pairs.push_back(pair_of(48'd1, 32'h10, 40'd0, 48'd1,
                                        48'd1, 32'h10, 40'h7F_FFFF_FFFF, '1));
        pending_pairs.push_back(pair_of(48'd1, 32'd0, 40'd0, 48'd1,
                                        48'd2, 32'd0, 40'd1, 48'd4));
        pending_pairs.push_back(pair_of(48'd1, 32'h1, 40'd0, 48'd0,
                                        48'd1, 32'h0, 40'd1, 48'd3));
        pending_pairs.push_back(pair_of(48'd1, '1, 40'h7F_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                        '0, '1, 40'h80_0000_0000, 48'h8000_0000_0000));
        pending_pairs.push_back(pair_of(48'd3, 32'h40_0000, 40'hFF_FFFF_FFFE, 48'd1,
                                        48'd1, 32'h40_0000, 40'd1, '1));
        pending_pairs.push_back(pair_of(48'd1, 32'h40_0000, 40'd0, 48'd1,
                                        48'd1, 32'h40_0000, 40'd1, 48'd2));
        drain_pipe();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_coeff(coeffs[ph]);
            for (int i = 0; i < 80; i++)
                pending_pairs.push_back(random_pair($urandom_range(0, 9) != 0));
            if (ph == 2)
                long_hold_req = 1'b1;
            drain_pipe();
        end

        $display("covered %0d merged and %0d pass-through results over 5 coefficients",
                 n_merged, n_passed);
        if (errors == 0 && expected_bodies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(12 * 200000);
        $display("FAILURE");
        $finish;
    end

endmodule
